// File: rtl/keyboard_typo_code_expander_top_macros.svh
// assertion macros for the keyboard typo code expander
// both expect clk and rst to be visible where they are used
`ifndef KEYBOARD_TYPO_CODE_EXPANDER_TOP_MACROS_SVH
`define KEYBOARD_TYPO_CODE_EXPANDER_TOP_MACROS_SVH

// consequence holds in the same cycle
`define KTE_CHECK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequence holds in the following cycle
`define KTE_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/kte_pkg.sv
package kte_pkg;

  // code geometry
  localparam int SLOTS        = 4;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int LETTER_W     = 5;
  localparam int LEN_W        = 3;
  localparam int MAX_CODE_LEN = 4;
  localparam int NUM_LETTERS  = 26;
  localparam int MAX_NB       = 4;
  localparam int NB_W         = $clog2(MAX_NB);
  localparam int NB_CNT_W     = $clog2(MAX_NB + 1);

  // candidate sequence: base, repeat, truncate, then slot/neighbour pairs
  localparam int GEN_BASE    = 0;
  localparam int GEN_REPEAT  = 1;
  localparam int GEN_TRUNC   = 2;
  localparam int GEN_NB_BASE = 3;
  localparam int CAND_NUM    = GEN_NB_BASE + SLOTS * MAX_NB;
  localparam int GEN_W       = $clog2(CAND_NUM);
  localparam int NB_SEL_W    = SLOT_W + NB_W;

  // sorted list of distinct candidates
  localparam int LIST_DEPTH = CAND_NUM;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // ordering key: one extra bit per slot so an empty slot sorts first
  localparam int KEY_SLOT_W = LETTER_W + 1;
  localparam int KEY_W      = SLOTS * KEY_SLOT_W;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    logic [LEN_W-1:0]        len;
    letter_t [SLOTS-1:0]     ch;
  } variant_t;

  typedef struct packed {
    logic load;
    logic gen_step;
    logic pop;
  } kte_cmd_t;

  typedef struct packed {
    logic gen_last;
    logic count_one;
    logic out_free;
  } kte_sts_t;

  // neighbour counts per letter
  localparam logic [NB_CNT_W-1:0] NB_COUNT [NUM_LETTERS] = '{
    3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2,
    3'd4, 3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd2
  };

  // keyboard neighbours per letter, unused entries zero
  localparam letter_t NB_TABLE [NUM_LETTERS][MAX_NB] = '{
    '{5'd18, 5'd16, 5'd25, 5'd0 },
    '{5'd13, 5'd21, 5'd5,  5'd6 },
    '{5'd21, 5'd23, 5'd3,  5'd0 },
    '{5'd5,  5'd18, 5'd4,  5'd2 },
    '{5'd17, 5'd22, 5'd3,  5'd0 },
    '{5'd6,  5'd3,  5'd17, 5'd21},
    '{5'd5,  5'd7,  5'd19, 5'd24},
    '{5'd6,  5'd9,  5'd24, 5'd13},
    '{5'd20, 5'd14, 5'd10, 5'd9 },
    '{5'd7,  5'd10, 5'd20, 5'd12},
    '{5'd9,  5'd11, 5'd8,  5'd0 },
    '{5'd10, 5'd14, 5'd0,  5'd0 },
    '{5'd9,  5'd13, 5'd0,  5'd0 },
    '{5'd1,  5'd12, 5'd7,  5'd9 },
    '{5'd8,  5'd15, 5'd11, 5'd0 },
    '{5'd14, 5'd11, 5'd0,  5'd0 },
    '{5'd22, 5'd0,  5'd0,  5'd0 },
    '{5'd19, 5'd4,  5'd5,  5'd1 },
    '{5'd3,  5'd0,  5'd22, 5'd23},
    '{5'd17, 5'd6,  5'd24, 5'd0 },
    '{5'd24, 5'd8,  5'd9,  5'd7 },
    '{5'd1,  5'd2,  5'd5,  5'd0 },
    '{5'd4,  5'd16, 5'd18, 5'd0 },
    '{5'd2,  5'd25, 5'd18, 5'd0 },
    '{5'd19, 5'd20, 5'd7,  5'd6 },
    '{5'd23, 5'd0,  5'd0,  5'd0 }
  };

  // letters outside a..z have no neighbours
  function automatic logic [NB_CNT_W-1:0] nb_count(letter_t c);
    if (c < letter_t'(NUM_LETTERS)) begin
      return NB_COUNT[c];
    end
    return '0;
  endfunction

  function automatic letter_t nb_letter(letter_t c, logic [NB_W-1:0] j);
    if (c < letter_t'(NUM_LETTERS)) begin
      return NB_TABLE[c][j];
    end
    return '0;
  endfunction

  // slot 0 most significant, letter plus one, zero past the length
  function automatic logic [KEY_W-1:0] variant_key(variant_t v);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (s < int'(v.len)) begin
        key[KEY_W-1-s*KEY_SLOT_W -: KEY_SLOT_W] = {1'b0, v.ch[s]} + KEY_SLOT_W'(1);
      end
    end
    return key;
  endfunction

endpackage

// File: rtl/kte_in_if.sv
interface kte_in_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             code_length;
  logic [4:0]             letter_0;
  logic [4:0]             letter_1;
  logic [4:0]             letter_2;
  logic [4:0]             letter_3;

  modport source (
    output valid, code_length, letter_0, letter_1, letter_2, letter_3,
    input  ready
  );
  modport sink (
    input  valid, code_length, letter_0, letter_1, letter_2, letter_3,
    output ready
  );
endinterface

// File: rtl/kte_out_if.sv
interface kte_out_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             variant_length;
  logic [4:0]             variant_0;
  logic [4:0]             variant_1;
  logic [4:0]             variant_2;
  logic [4:0]             variant_3;
  logic                   last_variant;

  modport source (
    output valid, variant_length, variant_0, variant_1, variant_2, variant_3,
           last_variant,
    input  ready
  );
  modport sink (
    input  valid, variant_length, variant_0, variant_1, variant_2, variant_3,
           last_variant,
    output ready
  );
endinterface

// File: rtl/kte_ctrl.sv
module kte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              code_valid,
  output logic              code_ready,
  input  kte_pkg::kte_sts_t sts,
  output kte_pkg::kte_cmd_t cmd
);
  import kte_pkg::*;

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    GEN  = 3'b010,
    EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // commands to the datapath
  always_comb begin
    code_ready   = (state == IDLE);
    cmd.load     = (state == IDLE) && code_valid;
    cmd.gen_step = (state == GEN);
    cmd.pop      = (state == EMIT) && sts.out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (code_valid) begin
          state_next = GEN;
        end
      end
      GEN: begin
        if (sts.gen_last) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        if (sts.out_free && sts.count_one) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/kte_datapath.sv
module kte_datapath (
  input  logic              clk,
  input  logic              rst,
  kte_in_if.sink            code,
  kte_out_if.source         variant,
  input  kte_pkg::kte_cmd_t cmd,
  output kte_pkg::kte_sts_t sts
);
  import kte_pkg::*;

  variant_t                base;
  logic [GEN_W-1:0]        gen_idx;
  variant_t                list [LIST_DEPTH];
  logic [CNT_W-1:0]        count;
  variant_t                out_item;
  logic                    out_last;
  logic                    out_valid;

  variant_t                in_item;
  letter_t [SLOTS-1:0]     in_ch;
  variant_t                cand;
  logic                    cand_valid;
  logic [NB_SEL_W-1:0]     nb_sel;
  logic [SLOT_W-1:0]       nb_slot;
  logic [NB_W-1:0]         nb_pick;
  logic [SLOT_W-1:0]       last_slot;
  letter_t                 nb_src;
  logic [KEY_W-1:0]        cand_key;
  logic [LIST_DEPTH-1:0]   lt;
  logic [LIST_DEPTH-1:0]   eq;
  logic                    insert;

  // clamp the length and zero letters past it
  assign in_ch[0] = code.letter_0;
  assign in_ch[1] = code.letter_1;
  assign in_ch[2] = code.letter_2;
  assign in_ch[3] = code.letter_3;

  always_comb begin
    in_item = '0;
    if (code.code_length == '0) begin
      in_item.len = LEN_W'(1);
    end else if (code.code_length > LEN_W'(SLOTS)) begin
      in_item.len = LEN_W'(SLOTS);
    end else begin
      in_item.len = code.code_length;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (s < int'(in_item.len)) begin
        in_item.ch[s] = in_ch[s];
      end
    end
  end

  // candidate for the current step of the sequence
  assign nb_sel    = NB_SEL_W'(gen_idx - GEN_W'(GEN_NB_BASE));
  assign nb_slot   = nb_sel[NB_SEL_W-1 -: SLOT_W];
  assign nb_pick   = nb_sel[NB_W-1:0];
  assign last_slot = SLOT_W'(base.len - LEN_W'(1));
  assign nb_src    = base.ch[nb_slot];

  always_comb begin
    cand       = base;
    cand_valid = 1'b0;
    if (gen_idx == GEN_W'(GEN_BASE)) begin
      cand_valid = 1'b1;
    end else if (gen_idx == GEN_W'(GEN_REPEAT)) begin
      cand_valid = (base.len < LEN_W'(MAX_CODE_LEN)) && (base.len < LEN_W'(SLOTS));
      if (cand_valid) begin
        cand.ch[SLOT_W'(base.len)] = base.ch[last_slot];
        cand.len                   = base.len + LEN_W'(1);
      end
    end else if (gen_idx == GEN_W'(GEN_TRUNC)) begin
      cand_valid = (base.len > LEN_W'(1));
      cand.ch[last_slot] = '0;
      cand.len           = base.len - LEN_W'(1);
    end else begin
      cand_valid = (LEN_W'(nb_slot) < base.len) &&
                   (NB_CNT_W'(nb_pick) < nb_count(nb_src));
      cand.ch[nb_slot] = nb_letter(nb_src, nb_pick);
    end
  end

  // compare the candidate against every list entry
  assign cand_key = variant_key(cand);

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count) && (variant_key(list[i]) < cand_key);
      eq[i] = (CNT_W'(i) < count) && (variant_key(list[i]) == cand_key);
    end
  end

  assign insert = cmd.gen_step && cand_valid && !(|eq);

  // sorted list: insert in place, or shift toward the head on pop
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_list
    always_ff @(posedge clk) begin
      if (insert) begin
        if (!lt[i]) begin
          if (i == 0) begin
            list[i] <= cand;
          end else if (lt[(i > 0) ? i - 1 : 0]) begin
            list[i] <= cand;
          end else begin
            list[i] <= list[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (cmd.pop && (i < LIST_DEPTH - 1)) begin
        list[i] <= list[(i < LIST_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // base capture and sequence step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_idx <= '0;
      count   <= '0;
    end else begin
      if (cmd.load) begin
        gen_idx <= '0;
        count   <= '0;
      end else if (cmd.gen_step) begin
        gen_idx <= gen_idx + GEN_W'(1);
        if (insert) begin
          count <= count + CNT_W'(1);
        end
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_item <= list[0];
      out_last <= (count == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop) begin
      out_valid <= 1'b1;
    end else if (variant.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign variant.valid          = out_valid;
  assign variant.variant_length = out_item.len;
  assign variant.variant_0      = out_item.ch[0];
  assign variant.variant_1      = out_item.ch[1];
  assign variant.variant_2      = out_item.ch[2];
  assign variant.variant_3      = out_item.ch[3];
  assign variant.last_variant   = out_last;

  // status to the controller
  assign sts.gen_last  = (gen_idx == GEN_W'(CAND_NUM - 1));
  assign sts.count_one = (count == CNT_W'(1));
  assign sts.out_free  = !out_valid || variant.ready;

endmodule

// File: rtl/keyboard_typo_code_expander_top.sv
// Keyboard typo code expander. Each accepted code of 1 to 4 letters yields
// between 2 and 18 variant items in ascending order, duplicates removed,
// with last_variant set on the final one. After a code is accepted, the
// candidate sequence (the code, its repeat and truncate forms, then every
// slot and neighbour pair) steps once a cycle into a sorted insertion list,
// then the list pops into the output register one variant per cycle while
// the sink is not stalling. The next code is taken once the last variant
// sits in the output register.
`include "keyboard_typo_code_expander_top_macros.svh"

module keyboard_typo_code_expander_top (
  input  logic      clk,
  input  logic      rst,
  kte_in_if.sink    code,
  kte_out_if.source variant
);
  import kte_pkg::*;

  kte_cmd_t cmd;
  kte_sts_t sts;
  logic     code_ready;

  // the sequencer owns the input handshake
  kte_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code.valid),
    .code_ready (code_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  assign code.ready = code_ready;

  kte_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .code    (code),
    .variant (variant),
    .cmd     (cmd),
    .sts     (sts)
  );

  // checks on sequencing
  `KTE_CHECK_NEXT(a_busy_after_accept, code.valid && code.ready, !code.ready)
  `KTE_CHECK_NEXT(a_pop_shows_item, cmd.pop, variant.valid)
  `KTE_CHECK_SAME(a_cmd_exclusive, cmd.load, !cmd.gen_step && !cmd.pop)
  `KTE_CHECK_SAME(a_no_accept_while_emitting, cmd.pop, !code.ready)

endmodule

// File: tb/keyboard_typo_code_expander_top_test.sv
module keyboard_typo_code_expander_top_test;

  localparam int SLOTS        = kte_pkg::SLOTS;
  localparam int NUM_LETTERS  = kte_pkg::NUM_LETTERS;
  localparam int MAX_CANDS    = 20;
  localparam int RANDOM_CODES = 390;
  localparam int CALM_CODES   = 60;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [2:0]      len;
    logic [0:3][4:0] ch;
  } spelling_t;

  typedef struct packed {
    spelling_t word;
    logic      last;
  } variant_item_t;

  typedef struct {
    logic [2:0]      len_field;
    logic [0:3][4:0] letters;
    int              gap_after;
    bit              drain_first;
  } code_item_t;

  // neighbouring keys per letter, a..z
  localparam int NEIGHBOUR_COUNT [NUM_LETTERS] = '{
    3, 4, 3, 4, 3, 4, 4, 4, 4, 4, 3, 2, 2,
    4, 3, 2, 2, 4, 4, 3, 4, 3, 3, 3, 4, 2
  };

  localparam logic [4:0] NEIGHBOUR_LIST [NUM_LETTERS][4] = '{
    '{18, 16, 25, 0},  // a: s q z
    '{13, 21, 5, 6},   // b: n v f g
    '{21, 23, 3, 0},   // c: v x d
    '{5, 18, 4, 2},    // d: f s e c
    '{17, 22, 3, 0},   // e: r w d
    '{6, 3, 17, 21},   // f: g d r v
    '{5, 7, 19, 24},   // g: f h t y
    '{6, 9, 24, 13},   // h: g j y n
    '{20, 14, 10, 9},  // i: u o k j
    '{7, 10, 20, 12},  // j: h k u m
    '{9, 11, 8, 0},    // k: j l i
    '{10, 14, 0, 0},   // l: k o
    '{9, 13, 0, 0},    // m: j n
    '{1, 12, 7, 9},    // n: b m h j
    '{8, 15, 11, 0},   // o: i p l
    '{14, 11, 0, 0},   // p: o l
    '{22, 0, 0, 0},    // q: w a
    '{19, 4, 5, 1},    // r: t e f b
    '{3, 0, 22, 23},   // s: d a w x
    '{17, 6, 24, 0},   // t: r g y
    '{24, 8, 9, 7},    // u: y i j h
    '{1, 2, 5, 0},     // v: b c f
    '{4, 16, 18, 0},   // w: e q s
    '{2, 25, 18, 0},   // x: c z s
    '{19, 20, 7, 6},   // y: t u h g
    '{23, 0, 0, 0}     // z: x a
  };

  logic clk;
  logic rst;

  kte_in_if  code_ch ();
  kte_out_if variant_ch ();

  keyboard_typo_code_expander_top u_top (
    .clk     (clk),
    .rst     (rst),
    .code    (code_ch),
    .variant (variant_ch)
  );

  code_item_t    pending_codes [$];
  variant_item_t expected_variants [$];
  code_item_t    cur_code;
  int            gap_left;
  int            stall_left;
  int            results_seen;
  int            calm_from;
  int            error_count;

  // lexicographic order, shorter prefix first
  function automatic int code_order(spelling_t a, spelling_t b);
    int n;
    n = (a.len < b.len) ? int'(a.len) : int'(b.len);
    for (int i = 0; i < n; i++) begin
      if (a.ch[i] != b.ch[i]) begin
        return (a.ch[i] < b.ch[i]) ? -1 : 1;
      end
    end
    if (a.len == b.len) begin
      return 0;
    end
    return (a.len < b.len) ? -1 : 1;
  endfunction

  // all tolerated variants of one code, sorted and distinct
  function automatic void expand_code(code_item_t c, ref variant_item_t vq[$]);
    spelling_t     cand [MAX_CANDS];
    spelling_t     base;
    spelling_t     v;
    spelling_t     t;
    variant_item_t r;
    int            len;
    int            n;
    int            k;
    int            kept;
    len = int'(c.len_field);
    if (len < 1) len = 1;
    if (len > SLOTS) len = SLOTS;
    base = '0;
    base.len = 3'(len);
    for (int i = 0; i < len; i++) begin
      base.ch[i] = c.letters[i];
    end
    n = 0;
    cand[n] = base;
    n++;
    // last letter doubled
    if (len < SLOTS) begin
      v = base;
      v.ch[len] = base.ch[len-1];
      v.len = 3'(len + 1);
      cand[n] = v;
      n++;
    end
    // last letter dropped
    if (len > 1) begin
      v = base;
      v.ch[len-1] = '0;
      v.len = 3'(len - 1);
      cand[n] = v;
      n++;
    end
    // one neighbour swap per slot
    for (int i = 0; i < len; i++) begin
      if (base.ch[i] < NUM_LETTERS) begin
        for (int j = 0; j < NEIGHBOUR_COUNT[base.ch[i]]; j++) begin
          v = base;
          v.ch[i] = NEIGHBOUR_LIST[base.ch[i]][j];
          if (n < MAX_CANDS) begin
            cand[n] = v;
            n++;
          end
        end
      end
    end
    // insertion sort
    for (int i = 1; i < n; i++) begin
      t = cand[i];
      k = i;
      while (k > 0 && code_order(cand[k-1], t) > 0) begin
        cand[k] = cand[k-1];
        k--;
      end
      cand[k] = t;
    end
    // drop duplicates
    kept = 0;
    for (int i = 0; i < n; i++) begin
      if (kept == 0 || code_order(cand[kept-1], cand[i]) != 0) begin
        cand[kept] = cand[i];
        kept++;
      end
    end
    for (int i = 0; i < kept; i++) begin
      r.word = cand[i];
      r.last = (i == kept - 1);
      vq.insert(vq.size(), r);
    end
  endfunction

  task automatic add_code(input int len, input int l0, input int l1, input int l2,
                          input int l3, input int gap, input bit drain);
    code_item_t c;
    c.len_field   = 3'(len);
    c.letters[0]  = 5'(l0);
    c.letters[1]  = 5'(l1);
    c.letters[2]  = 5'(l2);
    c.letters[3]  = 5'(l3);
    c.gap_after   = gap;
    c.drain_first = drain;
    pending_codes.insert(pending_codes.size(), c);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // code driver
  always @(posedge clk) begin
    if (rst) begin
      code_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (code_ch.valid && code_ch.ready) begin
        expand_code(cur_code, expected_variants);
        gap_left = cur_code.gap_after;
      end
      if (!code_ch.valid || code_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          code_ch.valid <= 1'b0;
        end else if (pending_codes.size() != 0 &&
                     !(pending_codes[0].drain_first && expected_variants.size() != 0)) begin
          cur_code = pending_codes.pop_front();
          code_ch.code_length <= cur_code.len_field;
          code_ch.letter_0    <= cur_code.letters[0];
          code_ch.letter_1    <= cur_code.letters[1];
          code_ch.letter_2    <= cur_code.letters[2];
          code_ch.letter_3    <= cur_code.letters[3];
          code_ch.valid       <= 1'b1;
        end else begin
          code_ch.valid <= 1'b0;
        end
      end
    end
  end

  // variant monitor and sink stalls
  always @(posedge clk) begin
    variant_item_t exp_v;
    if (!rst) begin
      if (variant_ch.valid && variant_ch.ready) begin
        results_seen++;
        if (expected_variants.size() == 0) begin
          $error("unexpected variant item: length %0d letters %0d %0d %0d %0d",
                 variant_ch.variant_length, variant_ch.variant_0, variant_ch.variant_1,
                 variant_ch.variant_2, variant_ch.variant_3);
          error_count++;
        end else begin
          exp_v = expected_variants.pop_front();
          if (variant_ch.variant_length !== exp_v.word.len) begin
            $error("variant_length: expected %0d, got %0d",
                   exp_v.word.len, variant_ch.variant_length);
            error_count++;
          end
          if (variant_ch.variant_0 !== exp_v.word.ch[0]) begin
            $error("variant_0: expected %0d, got %0d", exp_v.word.ch[0], variant_ch.variant_0);
            error_count++;
          end
          if (variant_ch.variant_1 !== exp_v.word.ch[1]) begin
            $error("variant_1: expected %0d, got %0d", exp_v.word.ch[1], variant_ch.variant_1);
            error_count++;
          end
          if (variant_ch.variant_2 !== exp_v.word.ch[2]) begin
            $error("variant_2: expected %0d, got %0d", exp_v.word.ch[2], variant_ch.variant_2);
            error_count++;
          end
          if (variant_ch.variant_3 !== exp_v.word.ch[3]) begin
            $error("variant_3: expected %0d, got %0d", exp_v.word.ch[3], variant_ch.variant_3);
            error_count++;
          end
          if (variant_ch.last_variant !== exp_v.last) begin
            $error("last_variant: expected %0d, got %0d", exp_v.last, variant_ch.last_variant);
            error_count++;
          end
        end
      end
      // stall bursts in alternating stretches, none near the end
      if (stall_left > 0) begin
        stall_left--;
        variant_ch.ready <= 1'b0;
      end else if (results_seen < calm_from && ((results_seen / 80) % 3) != 0 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        variant_ch.ready <= 1'b0;
      end else begin
        variant_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    variant_item_t tally [$];
    int            len;
    int            gap;
    int            n_codes;
    code_ch.valid       = 1'b0;
    code_ch.code_length = '0;
    code_ch.letter_0    = '0;
    code_ch.letter_1    = '0;
    code_ch.letter_2    = '0;
    code_ch.letter_3    = '0;
    variant_ch.ready    = 1'b0;
    rst                 = 1'b1;
    gap_left            = 0;
    stall_left          = 0;
    results_seen        = 0;
    error_count         = 0;
    calm_from           = 0;

    // directed codes
    add_code(1, 0, 0, 0, 0, 0, 0);       // single a
    add_code(1, 25, 0, 0, 0, 0, 0);      // single z
    add_code(1, 26, 5, 9, 2, 2, 0);      // letter above z, no neighbours
    add_code(1, 31, 31, 31, 31, 0, 0);
    add_code(0, 6, 9, 9, 9, 0, 0);       // length zero taken as one
    add_code(4, 1, 3, 5, 6, 0, 1);       // bdfg, most variants
    add_code(4, 25, 25, 25, 25, 3, 0);
    add_code(4, 31, 30, 29, 28, 0, 0);
    add_code(4, 0, 0, 0, 0, 0, 0);
    add_code(5, 7, 8, 9, 10, 0, 0);      // length saturates at four
    add_code(7, 31, 31, 31, 31, 0, 0);
    add_code(6, 26, 0, 12, 25, 5, 0);
    add_code(2, 0, 0, 31, 31, 0, 0);     // aa, ignored letters nonzero
    add_code(2, 16, 0, 0, 0, 0, 0);      // qa
    add_code(3, 11, 11, 11, 31, 0, 0);   // lll
    add_code(3, 15, 16, 25, 0, 0, 1);
    add_code(3, 19, 24, 6, 7, 0, 0);
    add_code(2, 28, 3, 0, 0, 1, 0);
    add_code(4, 18, 0, 22, 23, 0, 0);
    add_code(3, 30, 1, 26, 17, 0, 0);

    // random codes, mostly well formed
    for (int i = 0; i < RANDOM_CODES; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 4);
        add_code(len, $urandom_range(0, 25), $urandom_range(0, 25),
                 $urandom_range(0, 25), $urandom_range(0, 25), 0, 0);
      end else begin
        add_code($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 31), 0, 0);
      end
      // unused letters get random values too
      for (int s = 0; s < SLOTS; s++) begin
        if (s >= int'(pending_codes[$].len_field) && $urandom_range(0, 1) == 1) begin
          pending_codes[$].letters[s] = 5'($urandom_range(0, 31));
        end
      end
      pending_codes[$].drain_first = (i % 100 == 0);
    end

    // source gaps in stretches, none in the closing part
    n_codes = pending_codes.size();
    for (int i = 0; i < n_codes - CALM_CODES; i++) begin
      gap = 0;
      if (((i / 40) % 3) != 1 && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 15);
      end
      if (pending_codes[i].gap_after == 0) begin
        pending_codes[i].gap_after = gap;
      end
      expand_code(pending_codes[i], tally);
    end
    for (int i = n_codes - CALM_CODES; i < n_codes; i++) begin
      pending_codes[i].gap_after = 0;
    end
    calm_from = tally.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_codes.size() != 0 || code_ch.valid) @(posedge clk);
    while (expected_variants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_variants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
